/* rtl/square_tone_pcm_bytes_defines.svh */
// Assertion macros shared by the square tone PCM byte generator.
`ifndef SQUARE_TONE_PCM_BYTES_DEFINES_SVH
`define SQUARE_TONE_PCM_BYTES_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define STPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define STPB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/stpb_pkg.sv */
// Types and constants for the square tone PCM byte generator.
package stpb_pkg;

  localparam int MAX_BITS  = 32;
  localparam int DEPTH_CAP = (MAX_BITS < 32) ? MAX_BITS : 32;
  localparam int BYTE_BITS = 8;
  localparam int WORD_BITS = 32;
  localparam int BYTES_MAX = WORD_BITS / BYTE_BITS;
  localparam int CNT_W     = $clog2(BYTES_MAX);
  localparam int DEPTH_W   = 6;
  localparam int PHASE_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd42852281;
  localparam logic [PHASE_W-1:0] DUTY_LEVEL_RST = 32'd2147483648;
  localparam logic [DEPTH_W-1:0] BIT_DEPTH_RST  = 6'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_DUTY_LEVEL = 2'd1,
    CFG_BIT_DEPTH  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [PHASE_W-1:0] duty_level;
    logic [DEPTH_W-1:0] bit_depth;
  } cfg_regs_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] code;
    logic [CNT_W-1:0]     last_idx;
  } sample_t;

endpackage

/* rtl/stpb_front.sv */
// Front end: phase accumulator, level decision and sample coding.
module stpb_front (
  input  logic               clk,
  input  logic               rst,
  input  stpb_pkg::cfg_regs_t cfg,
  input  logic               push,
  input  logic               restart,
  input  logic               q_full,
  output logic               q_wr,
  output stpb_pkg::sample_t  q_wdata
);
  import stpb_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] cur_phase;
  logic               level_high;
  logic [DEPTH_W-1:0] depth;
  logic [CNT_W-1:0]   last_idx;
  logic [CNT_W:0]     nbytes;
  logic [DEPTH_W-1:0] span;
  logic [DEPTH_W-1:0] lo;
  logic               narrow;
  logic [WORD_BITS-1:0] code;

  assign q_wr = push && !q_full;

  always_comb begin
    cur_phase  = restart ? '0 : phase;
    level_high = (cur_phase <= cfg.duty_level);
    phase_next = cur_phase + cfg.phase_step;
  end

  // Clamp depth to the supported range, then work out the byte span.
  always_comb begin
    if (cfg.bit_depth == '0) begin
      depth = DEPTH_W'(1);
    end else if (cfg.bit_depth > DEPTH_W'(DEPTH_CAP)) begin
      depth = DEPTH_W'(DEPTH_CAP);
    end else begin
      depth = cfg.bit_depth;
    end
    last_idx = CNT_W'((depth - DEPTH_W'(1)) >> 3);
    nbytes   = {1'b0, last_idx} + (CNT_W+1)'(1);
    span     = DEPTH_W'({nbytes, 3'b000});
    lo       = span - depth;
    narrow   = (depth <= DEPTH_W'(BYTE_BITS));
  end

  // Left-justified code: offset binary when narrow, two's complement otherwise.
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      if (narrow) begin
        code[k] = level_high && (DEPTH_W'(k) < span) && (DEPTH_W'(k) >= lo);
      end else if (level_high) begin
        code[k] = (DEPTH_W'(k) < span - DEPTH_W'(1)) && (DEPTH_W'(k) >= lo);
      end else begin
        code[k] = (DEPTH_W'(k) == span - DEPTH_W'(1));
      end
    end
    q_wdata.code     = code;
    q_wdata.last_idx = last_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (q_wr) begin
      phase <= phase_next;
    end
  end

endmodule

/* rtl/stpb_queue.sv */
// Short sample queue between the front end and the byte serialiser.
module stpb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  stpb_pkg::sample_t wdata,
  input  logic              rd,
  output stpb_pkg::sample_t rdata,
  output logic              full,
  output logic              empty
);
  import stpb_pkg::*;

  sample_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/stpb_back.sv */
// Back end: serialise each queued sample into bytes, least significant first.
module stpb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  stpb_pkg::sample_t q_rdata,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        pcm_byte,
  output logic              last_byte
);
  import stpb_pkg::*;

  logic [WORD_BITS-1:0] word;
  logic [CNT_W-1:0]     left;
  logic                 loaded;
  logic                 take;
  logic                 done;

  assign empty     = !loaded;
  assign pcm_byte  = word[BYTE_BITS-1:0];
  assign last_byte = (left == '0);
  assign take      = loaded && pop;
  assign done      = take && (left == '0);
  assign q_rd      = (!loaded || done) && !q_empty;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      word <= q_rdata.code;
      left <= q_rdata.last_idx;
    end else if (take) begin
      word <= word >> BYTE_BITS;
      left <= left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
    end else if (q_rd) begin
      loaded <= 1'b1;
    end else if (done) begin
      loaded <= 1'b0;
    end
  end

endmodule

/* rtl/square_tone_pcm_bytes.sv */
// With the serialiser idle, a pushed sample is written into the queue and then loaded into the
//   holding register, where its first byte is presented and can itself transfer at the following edge.
// Throughput: the front end takes one sample per cycle while the queue has room; the
//   byte serialiser sends one byte per cycle while pop is high; a sample is ceil(depth/8) bytes (1 to 4).
// Reset (rst, synchronous): phase to zero, registers to their defaults, queue and output empty.
// Configuration writes are always ready and take effect in the cycle after the transfer.
module square_tone_pcm_bytes (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [stpb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stpb_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic                               restart,
  output logic                               empty,
  input  logic                               pop,
  output logic [7:0]                         pcm_byte,
  output logic                               last_byte
);
  import stpb_pkg::*;
  `include "square_tone_pcm_bytes_defines.svh"

  cfg_regs_t cfg;
  logic      q_wr;
  logic      q_rd;
  logic      q_full;
  logic      q_empty;
  sample_t   q_wdata;
  sample_t   q_rdata;

  // Register file: always ready, indexes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step <= PHASE_STEP_RST;
      cfg.duty_level <= DUTY_LEVEL_RST;
      cfg.bit_depth  <= BIT_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_STEP: cfg.phase_step <= cfg_data[PHASE_W-1:0];
        CFG_DUTY_LEVEL: cfg.duty_level <= cfg_data[PHASE_W-1:0];
        CFG_BIT_DEPTH:  cfg.bit_depth  <= cfg_data[DEPTH_W-1:0];
        default:        ;
      endcase
    end
  end

  // Front end: advance the phase and code the sample on each push transfer.
  stpb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .restart (restart),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  // Queue: hold coded samples so either side can stall on its own.
  stpb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back end: hand out bytes; the holding register is the output stage.
  stpb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .pcm_byte  (pcm_byte),
    .last_byte (last_byte)
  );

  assign full = q_full;

  // Bytes of one sample follow without a gap.
  `STPB_ASSERT(a_bytes_contiguous, (!empty && pop && !last_byte) |=> !empty, "gap inside a sample")
  // A pushed sample reaches the outputs through the queue and the holding register.
  `STPB_ASSERT(a_push_reaches_out, (push && !full) |=> ##1 !empty, "pushed sample not presented")
  // Nothing is presented straight after reset.
  `STPB_ASSERT_ALWAYS(a_empty_after_rst, rst |=> (empty && !full), "not empty after reset")

endmodule
